// ===== design/i2cram_pkg.sv =====
package i2cram_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_ACK_TIMEOUT    = 1'b1;

  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd93;
  localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        sda_in;
    logic [15:0] reg_address;
    logic [7:0]  write_data;
    logic [7:0]  byte_count;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       last_byte;
    logic       done_res;
    logic       nack;
    logic       busy_res;
  } result_t;

endpackage

// ===== design/i2cram_seq.sv =====
module i2cram_seq
  import i2cram_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  item_t      item,
  input  logic [6:0] device_address,
  input  logic [7:0] ack_timeout,
  output result_t    res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_HOLD, PH_TX_LO, PH_TX_HI, PH_ACK_LO, PH_ACK_HI,
    PH_RS_LO, PH_RS_HI, PH_RS_START, PH_RX_LO, PH_RX_HI, PH_MACK_LO,
    PH_MACK_HI, PH_STOP_LO, PH_STOP_HI
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  wait_cnt_r, wait_cnt_nxt;
  logic [15:0] reg_addr_r, reg_addr_nxt;
  logic [7:0]  wdata_r, wdata_nxt;
  logic        is_read_r, is_read_nxt;
  logic [1:0]  tx_idx_r, tx_idx_nxt;

  logic [3:0]  bit_cnt_inc;
  logic [7:0]  bytes_dec;

  assign bit_cnt_inc = bit_cnt_r + 4'd1;
  assign bytes_dec   = (bytes_left_r != 8'd0) ? bytes_left_r - 8'd1 : 8'd0;

  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    wait_cnt_nxt   = wait_cnt_r;
    reg_addr_nxt   = reg_addr_r;
    wdata_nxt      = wdata_r;
    is_read_nxt    = is_read_r;
    tx_idx_nxt     = tx_idx_r;
    res            = '0;

    if (phase_r == PH_IDLE) begin
      if (item.cmd == CMD_WRITE || item.cmd == CMD_READ) begin
        reg_addr_nxt   = item.reg_address;
        wdata_nxt      = item.write_data;
        bytes_left_nxt = item.byte_count;
        is_read_nxt    = (item.cmd == CMD_READ);
        bit_cnt_nxt    = 4'd0;
        shift_nxt      = 8'd0;
        wait_cnt_nxt   = 8'd0;
        tx_idx_nxt     = 2'd0;
        phase_nxt      = PH_START;
      end
    end else if (item.cmd == CMD_TICK) begin
      case (phase_r)
        PH_START: phase_nxt = PH_HOLD;
        PH_HOLD: begin
          bit_cnt_nxt = 4'd0;
          phase_nxt   = PH_TX_LO;
          if (tx_idx_r == 2'd3) begin
            shift_nxt = {device_address, 1'b1};
          end else begin
            tx_idx_nxt = 2'd0;
            shift_nxt  = {device_address, 1'b0};
          end
        end
        PH_TX_LO: phase_nxt = PH_TX_HI;
        PH_TX_HI: begin
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_cnt_nxt = bit_cnt_inc;
          if (bit_cnt_inc >= 4'd8) begin
            wait_cnt_nxt = 8'd0;
            phase_nxt    = PH_ACK_LO;
          end else begin
            phase_nxt = PH_TX_LO;
          end
        end
        PH_ACK_LO: phase_nxt = PH_ACK_HI;
        PH_ACK_HI: begin
          if (!item.sda_in) begin
            case (tx_idx_r)
              2'd0: begin
                tx_idx_nxt  = 2'd1;
                shift_nxt   = reg_addr_r[15:8];
                bit_cnt_nxt = 4'd0;
                phase_nxt   = PH_TX_LO;
              end
              2'd1: begin
                tx_idx_nxt  = 2'd2;
                shift_nxt   = reg_addr_r[7:0];
                bit_cnt_nxt = 4'd0;
                phase_nxt   = PH_TX_LO;
              end
              2'd2: begin
                if (is_read_r) begin
                  phase_nxt = PH_RS_LO;
                end else begin
                  tx_idx_nxt  = 2'd3;
                  shift_nxt   = wdata_r;
                  bit_cnt_nxt = 4'd0;
                  phase_nxt   = PH_TX_LO;
                end
              end
              default: begin
                if (is_read_r && bytes_left_r != 8'd0) begin
                  shift_nxt   = 8'd0;
                  bit_cnt_nxt = 4'd0;
                  phase_nxt   = PH_RX_LO;
                end else begin
                  phase_nxt = PH_STOP_LO;
                end
              end
            endcase
          end else if (wait_cnt_r >= ack_timeout) begin
            res.nack  = 1'b1;
            phase_nxt = PH_STOP_LO;
          end else begin
            wait_cnt_nxt = wait_cnt_r + 8'd1;
          end
        end
        PH_RS_LO: phase_nxt = PH_RS_HI;
        PH_RS_HI: phase_nxt = PH_RS_START;
        PH_RS_START: begin
          tx_idx_nxt = 2'd3;
          phase_nxt  = PH_HOLD;
        end
        PH_RX_LO: phase_nxt = PH_RX_HI;
        PH_RX_HI: begin
          shift_nxt   = {shift_r[6:0], item.sda_in};
          bit_cnt_nxt = bit_cnt_inc;
          if (bit_cnt_inc >= 4'd8) begin
            res.read_byte  = {shift_r[6:0], item.sda_in};
            res.byte_valid = 1'b1;
            res.last_byte  = (bytes_left_r <= 8'd1);
            phase_nxt      = PH_MACK_LO;
          end else begin
            phase_nxt = PH_RX_LO;
          end
        end
        PH_MACK_LO: phase_nxt = PH_MACK_HI;
        PH_MACK_HI: begin
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == 8'd0) begin
            phase_nxt = PH_STOP_LO;
          end else begin
            shift_nxt   = 8'd0;
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_RX_LO;
          end
        end
        PH_STOP_LO: phase_nxt = PH_STOP_HI;
        PH_STOP_HI: begin
          res.done_res = 1'b1;
          phase_nxt    = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    // bus levels after this tick
    case (phase_nxt)
      PH_START:    begin res.scl_level = 1'b1; res.sda_pull_low = 1'b1; end
      PH_HOLD:     begin res.scl_level = 1'b0; res.sda_pull_low = 1'b1; end
      PH_TX_LO:    begin res.scl_level = 1'b0; res.sda_pull_low = ~shift_nxt[7]; end
      PH_TX_HI:    begin res.scl_level = 1'b1; res.sda_pull_low = ~shift_nxt[7]; end
      PH_ACK_LO:   begin res.scl_level = 1'b0; res.sda_pull_low = 1'b0; end
      PH_ACK_HI:   begin res.scl_level = 1'b1; res.sda_pull_low = 1'b0; end
      PH_RS_LO:    begin res.scl_level = 1'b0; res.sda_pull_low = 1'b0; end
      PH_RS_HI:    begin res.scl_level = 1'b1; res.sda_pull_low = 1'b0; end
      PH_RS_START: begin res.scl_level = 1'b1; res.sda_pull_low = 1'b1; end
      PH_RX_LO:    begin res.scl_level = 1'b0; res.sda_pull_low = 1'b0; end
      PH_RX_HI:    begin res.scl_level = 1'b1; res.sda_pull_low = 1'b0; end
      PH_MACK_LO: begin
        res.scl_level    = 1'b0;
        res.sda_pull_low = (bytes_left_nxt > 8'd1);
      end
      PH_MACK_HI: begin
        res.scl_level    = 1'b1;
        res.sda_pull_low = (bytes_left_nxt > 8'd1);
      end
      PH_STOP_LO:  begin res.scl_level = 1'b0; res.sda_pull_low = 1'b1; end
      PH_STOP_HI:  begin res.scl_level = 1'b1; res.sda_pull_low = 1'b1; end
      default:     begin res.scl_level = 1'b1; res.sda_pull_low = 1'b0; end
    endcase
    res.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_cnt_r    <= 4'd0;
      shift_r      <= 8'd0;
      bytes_left_r <= 8'd0;
      wait_cnt_r   <= 8'd0;
      reg_addr_r   <= 16'd0;
      wdata_r      <= 8'd0;
      is_read_r    <= 1'b0;
      tx_idx_r     <= 2'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      wait_cnt_r   <= wait_cnt_nxt;
      reg_addr_r   <= reg_addr_nxt;
      wdata_r      <= wdata_nxt;
      is_read_r    <= is_read_nxt;
      tx_idx_r     <= tx_idx_nxt;
    end
  end

endmodule

// ===== design/i2c_register_access_master.sv =====
// A word is taken into the input register, then the sequencer steps it
// into the output register. Throughput: one word per cycle while the output
// is not stalled; the sequencer moves one phase per tick word while busy.
// A stalled output word holds the input register; only an empty one takes a word then.
// Reset (synchronous, rst_n low): sequencer idle, pipeline empty,
// device_address 93, ack_timeout 250.
module i2c_register_access_master
  import i2cram_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic        in_sda_in,
  input  logic [15:0] in_reg_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_level,
  output logic        out_sda_pull_low,
  output logic [7:0]  out_read_byte,
  output logic        out_byte_valid,
  output logic        out_last_byte,
  output logic        out_done_res,
  output logic        out_nack,
  output logic        out_busy_res
);

  logic [6:0] dev_addr_r;
  logic [7:0] ack_timeout_r;
  logic       s1_valid_r;
  item_t      s1_item_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    step_res;
  logic       s1_adv;
  logic       step;
  logic       in_acc;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= DEVICE_ADDRESS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: dev_addr_r    <= cfg_wdata[6:0];
        CFG_ACK_TIMEOUT:    ack_timeout_r <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= '{cmd: in_cmd, sda_in: in_sda_in, reg_address: in_reg_address,
                     write_data: in_write_data, byte_count: in_byte_count};
    end
  end

  i2cram_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .item           (s1_item_r),
    .device_address (dev_addr_r),
    .ack_timeout    (ack_timeout_r),
    .res            (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_level    = out_res_r.scl_level;
  assign out_sda_pull_low = out_res_r.sda_pull_low;
  assign out_read_byte    = out_res_r.read_byte;
  assign out_byte_valid   = out_res_r.byte_valid;
  assign out_last_byte    = out_res_r.last_byte;
  assign out_done_res     = out_res_r.done_res;
  assign out_nack         = out_res_r.nack;
  assign out_busy_res     = out_res_r.busy_res;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with empty input register");

  a_done_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && out_scl_level && !out_sda_pull_low)
    else $error("stop completion without idle bus");

  a_nack_goes_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nack |-> out_busy_res && !out_scl_level && out_sda_pull_low)
    else $error("acknowledge timeout not followed by stop");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_read_byte == 8'd0 && !out_last_byte)
    else $error("read byte flags without a completed byte");

endmodule
